[rtl/core/bcl_pkg.sv]
package bcl_pkg;

  // Character codes the scanner looks for
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Queue between scanner and emitter
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One classified input byte: one or two output bytes
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;
    logic       last;
  } entry_t;

endpackage

[rtl/core/bcl_front.sv]
module bcl_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output logic            wr_en,
  output bcl_pkg::entry_t wr_entry
);
  import bcl_pkg::*;

  typedef enum logic [2:0] {
    MODE_CODE  = 3'd0,
    MODE_LINE  = 3'd1,
    MODE_BLOCK = 3'd2,
    MODE_STR   = 3'd3,
    MODE_CHR   = 3'd4
  } mode_t;

  mode_t      mode, mode_next;
  logic       slash_held, slash_held_next;
  logic       star_seen, star_seen_next;
  logic       escape_next, escape_next_next;
  logic [1:0] n;
  logic [7:0] b0, b1;
  logic       cb_n;
  logic [7:0] cb_byte;
  logic [7:0] quote;

  // Result of a byte taken in code mode, with no slash pending
  always_comb begin
    cb_n    = 1'b1;
    cb_byte = in_byte;
    if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE) begin
      cb_byte = CH_SPACE;
    end else if (in_byte == CH_SLASH && !in_last) begin
      cb_n = 1'b0;
    end
  end

  always_comb begin
    mode_next        = mode;
    slash_held_next  = slash_held;
    star_seen_next   = star_seen;
    escape_next_next = escape_next;
    n     = 2'd1;
    b0    = CH_SPACE;
    b1    = CH_SPACE;
    quote = (mode == MODE_STR) ? CH_DQUOTE : CH_SQUOTE;
    case (mode)
      MODE_LINE: begin
        if (in_byte == CH_NL) begin
          b0        = CH_NL;
          mode_next = MODE_CODE;
        end
      end
      MODE_BLOCK: begin
        if (star_seen && in_byte == CH_SLASH) begin
          mode_next      = MODE_CODE;
          star_seen_next = 1'b0;
        end else begin
          star_seen_next = (in_byte == CH_STAR);
          if (in_byte == CH_NL) b0 = CH_NL;
        end
      end
      MODE_STR, MODE_CHR: begin
        if (escape_next) begin
          escape_next_next = 1'b0;
        end else if (in_byte == CH_BSLASH) begin
          b0               = CH_BSLASH;
          escape_next_next = 1'b1;
        end else if (in_byte == quote) begin
          mode_next = MODE_CODE;
        end else if (in_byte == CH_NL) begin
          b0 = CH_NL;
        end
      end
      default: begin
        mode_next = MODE_CODE;
        if (slash_held && in_byte == CH_SLASH) begin
          slash_held_next = 1'b0;
          n               = 2'd2;
          mode_next       = MODE_LINE;
        end else if (slash_held && in_byte == CH_STAR) begin
          slash_held_next = 1'b0;
          n               = 2'd2;
          mode_next       = MODE_BLOCK;
          star_seen_next  = 1'b0;
        end else begin
          // release the held slash, then the byte itself
          if (slash_held) begin
            b0 = CH_SLASH;
            b1 = cb_byte;
            n  = {1'b0, 1'b1} + {1'b0, cb_n};
          end else begin
            b0 = cb_byte;
            n  = {1'b0, cb_n};
          end
          slash_held_next = (in_byte == CH_SLASH) && !in_last;
          if (in_byte == CH_DQUOTE) begin
            mode_next        = MODE_STR;
            escape_next_next = 1'b0;
          end else if (in_byte == CH_SQUOTE) begin
            mode_next        = MODE_CHR;
            escape_next_next = 1'b0;
          end
        end
      end
    endcase
    if (in_last) begin
      mode_next        = MODE_CODE;
      slash_held_next  = 1'b0;
      star_seen_next   = 1'b0;
      escape_next_next = 1'b0;
    end
  end

  assign wr_en          = accept && (n != 2'd0);
  assign wr_entry.byte0 = b0;
  assign wr_entry.byte1 = b1;
  assign wr_entry.two   = (n == 2'd2);
  assign wr_entry.last  = in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_CODE;
      slash_held  <= 1'b0;
      star_seen   <= 1'b0;
      escape_next <= 1'b0;
    end else if (accept) begin
      mode        <= mode_next;
      slash_held  <= slash_held_next;
      star_seen   <= star_seen_next;
      escape_next <= escape_next_next;
    end
  end

  a_slash_in_code: assert property (@(posedge clk) disable iff (rst)
    slash_held |-> (mode == MODE_CODE))
    else $error("slash held outside code");

  a_star_in_block: assert property (@(posedge clk) disable iff (rst)
    star_seen |-> (mode == MODE_BLOCK))
    else $error("star flag outside block comment");

  a_escape_in_lit: assert property (@(posedge clk) disable iff (rst)
    escape_next |-> (mode == MODE_STR || mode == MODE_CHR))
    else $error("escape flag outside literal");

endmodule

[rtl/core/bcl_queue.sv]
module bcl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  bcl_pkg::entry_t wr_entry,
  output logic            q_full,
  input  logic            rd_en,
  output bcl_pkg::entry_t rd_entry,
  output logic            q_empty
);
  import bcl_pkg::*;

  entry_t              slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_wr, do_rd;

  assign q_full   = (count == QCNT_W'(QDEPTH));
  assign q_empty  = (count == '0);
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && !q_empty;
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count overflow");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[QPTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule

[rtl/core/bcl_back.sv]
module bcl_back (
  input  logic            clk,
  input  logic            rst,
  input  bcl_pkg::entry_t rd_entry,
  input  logic            q_empty,
  output logic            rd_en,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            out_last
);
  import bcl_pkg::*;

  logic out_valid;
  logic second;
  logic load;

  assign empty = !out_valid;
  assign load  = (!out_valid || pop) && !q_empty;
  // free the entry once its final byte moves into the output register
  assign rd_en = load && (second || !rd_entry.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        second    <= !second && rd_entry.two;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= second ? rd_entry.byte1 : rd_entry.byte0;
      out_last <= rd_entry.last && (second || !rd_entry.two);
    end
  end

  a_second_has_entry: assert property (@(posedge clk) disable iff (rst)
    second |-> !q_empty)
    else $error("second half pending with queue empty");

  a_fill_output: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !q_empty) |=> out_valid)
    else $error("output register not filled from waiting entry");

endmodule

[rtl/core/blank_comments_and_literals.sv]
// An accepted transaction is written into the queue, then moved into the output register,
//   from which it can be popped.
// Throughput: one input byte per cycle while the queue has room; a byte releasing two results
//   (held slash) becomes two output transactions, absorbed by the 4-entry queue between
//   scanner and emitter. A byte that releases nothing (held slash) writes no queue entry.
// Reset (rst, synchronous, active high) returns the scanner to code mode and empties the
//   queue and output register; no clearing pass is needed.
module blank_comments_and_literals (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import bcl_pkg::*;

  entry_t wr_entry, rd_entry;
  logic   wr_en, rd_en;
  logic   q_full, q_empty;
  logic   accept;

  // Hold input while the queue is full; the scanner advances only on an accepted transaction.
  assign full   = q_full;
  assign accept = push && !q_full;

  // Front: track comment and literal context and classify each byte.
  bcl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .wr_en    (wr_en),
    .wr_entry (wr_entry)
  );

  // Queue: decouple the scanner from the emitter so each side can stall alone.
  bcl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .q_full   (q_full),
    .rd_en    (rd_en),
    .rd_entry (rd_entry),
    .q_empty  (q_empty)
  );

  // Back: split entries into single output transactions behind an output register.
  bcl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_entry (rd_entry),
    .q_empty  (q_empty),
    .rd_en    (rd_en),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import bcl_pkg::*;

  // Give up after this many cycles; a correct run needs a small fraction of it
  localparam int CYCLE_LIMIT = 200000;
  // Cycles to let pass once the last expected byte is in
  localparam int DRAIN_CYCLES = 8;
  // Random stimulus is spread evenly over the idling phases below
  localparam int PHASE_ITEMS = 282;
  localparam int NPHASE = 4;
  // Percent of cycles the sender idles and the receiver stalls, per phase
  localparam int SND_IDLE [NPHASE] = '{0, 61, 0, 35};
  localparam int RCV_STALL [NPHASE] = '{0, 0, 61, 35};

  // Scanner modes of the predictor
  typedef enum logic [2:0] {
    SCAN_CODE,
    SCAN_LINE,
    SCAN_BLOCK,
    SCAN_STR,
    SCAN_CHR
  } scan_e;

  // One masked output byte as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } masked_t;

  // One directed row: input byte, frame end, whether the result is typed in,
  // how many bytes it releases and their values
  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic       chk;
    logic [1:0] n;
    logic [7:0] e0;
    logic [7:0] e1;
  } row_t;

  localparam int NDIR = 27;
  localparam row_t DIR_TAB [NDIR] = '{
    // plain byte after reset passes untouched
    '{8'h00,     1'b0, 1'b1, 2'd1, 8'h00,     CH_SPACE},
    // held slash, then a second slash opens a line comment
    '{CH_SLASH,  1'b0, 1'b1, 2'd0, CH_SPACE,  CH_SPACE},
    '{CH_SLASH,  1'b0, 1'b1, 2'd2, CH_SPACE,  CH_SPACE},
    '{8'hFF,     1'b0, 1'b1, 2'd1, CH_SPACE,  CH_SPACE},
    // newline closes the line comment and is kept
    '{CH_NL,     1'b0, 1'b1, 2'd1, CH_NL,     CH_SPACE},
    // slash star opens a block comment; the opening star must not close it
    '{CH_SLASH,  1'b0, 1'b1, 2'd0, CH_SPACE,  CH_SPACE},
    '{CH_STAR,   1'b0, 1'b1, 2'd2, CH_SPACE,  CH_SPACE},
    '{CH_SLASH,  1'b0, 1'b1, 2'd1, CH_SPACE,  CH_SPACE},
    '{CH_STAR,   1'b0, 1'b0, 2'd0, CH_SPACE,  CH_SPACE},
    '{CH_STAR,   1'b0, 1'b0, 2'd0, CH_SPACE,  CH_SPACE},
    '{CH_SLASH,  1'b0, 1'b1, 2'd1, CH_SPACE,  CH_SPACE},
    // held slash released by an ordinary byte: two bytes out at once
    '{CH_SLASH,  1'b0, 1'b1, 2'd0, CH_SPACE,  CH_SPACE},
    '{8'h61,     1'b0, 1'b1, 2'd2, CH_SLASH,  8'h61},
    // string with an escaped quote and a kept newline
    '{CH_DQUOTE, 1'b0, 1'b1, 2'd1, CH_SPACE,  CH_SPACE},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd1, CH_BSLASH, CH_SPACE},
    '{CH_DQUOTE, 1'b0, 1'b1, 2'd1, CH_SPACE,  CH_SPACE},
    '{CH_NL,     1'b0, 1'b1, 2'd1, CH_NL,     CH_SPACE},
    '{CH_DQUOTE, 1'b0, 1'b1, 2'd1, CH_SPACE,  CH_SPACE},
    // char literal with an escaped newline, which is blanked
    '{CH_SQUOTE, 1'b0, 1'b1, 2'd1, CH_SPACE,  CH_SPACE},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd1, CH_BSLASH, CH_SPACE},
    '{CH_NL,     1'b0, 1'b1, 2'd1, CH_SPACE,  CH_SPACE},
    '{CH_SQUOTE, 1'b0, 1'b1, 2'd1, CH_SPACE,  CH_SPACE},
    // held slash released together with the final byte of a frame
    '{CH_SLASH,  1'b0, 1'b1, 2'd0, CH_SPACE,  CH_SPACE},
    '{CH_DQUOTE, 1'b1, 1'b1, 2'd2, CH_SLASH,  CH_SPACE},
    // frame ends on a dangling escape inside a string
    '{CH_DQUOTE, 1'b0, 1'b1, 2'd1, CH_SPACE,  CH_SPACE},
    '{CH_BSLASH, 1'b1, 1'b1, 2'd1, CH_BSLASH, CH_SPACE},
    // slash as the final byte goes out at once
    '{CH_SLASH,  1'b1, 1'b1, 2'd1, CH_SLASH,  CH_SPACE}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  // Predictor state
  scan_e scan_st = SCAN_CODE;
  logic  slash_pend = 1'b0;
  logic  star_prev = 1'b0;
  logic  esc_pend = 1'b0;

  masked_t    masked_q [$];   // bytes the block still owes, oldest first
  row_t       typed_q [$];    // directed rows in flight, matched at acceptance
  logic [7:0] frag_q [$];     // bytes of the frame being built
  int         snd_idle = 0;
  int         rcv_stall = 0;
  int         errors = 0;
  int         sent = 0;
  int         cycles = 0;

  blank_comments_and_literals dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_byte (in_byte),
    .in_last (in_last),
    .empty   (empty),
    .pop     (pop),
    .out_byte(out_byte),
    .out_last(out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Append one byte to the tail of what the block owes
  function automatic void owe_byte(input masked_t m);
    masked_q.insert(masked_q.size(), m);
  endfunction

  // Append one byte to the frame being built
  function automatic void frag_add(input logic [7:0] c);
    frag_q.insert(frag_q.size(), c);
  endfunction

  // Advance the predictor by one source byte; return how many bytes it
  // releases (zero, one or two) in r0 and r1
  function automatic int blank_step(input logic [7:0] b, input logic l,
                                    output logic [7:0] r0, output logic [7:0] r1);
    int         n;
    logic [7:0] q;
    logic [7:0] c;
    n  = 0;
    r0 = CH_SPACE;
    r1 = CH_SPACE;
    case (scan_st)
      SCAN_LINE: begin
        n = 1;
        if (b == CH_NL) begin
          r0      = CH_NL;
          scan_st = SCAN_CODE;
        end
      end
      SCAN_BLOCK: begin
        n = 1;
        if (star_prev && b == CH_SLASH) begin
          scan_st   = SCAN_CODE;
          star_prev = 1'b0;
        end else begin
          star_prev = (b == CH_STAR);
          r0        = (b == CH_NL) ? CH_NL : CH_SPACE;
        end
      end
      SCAN_STR, SCAN_CHR: begin
        q = (scan_st == SCAN_STR) ? CH_DQUOTE : CH_SQUOTE;
        n = 1;
        if (esc_pend) begin
          esc_pend = 1'b0;
        end else if (b == CH_BSLASH) begin
          r0       = CH_BSLASH;
          esc_pend = 1'b1;
        end else if (b == q) begin
          scan_st = SCAN_CODE;
        end else begin
          r0 = (b == CH_NL) ? CH_NL : CH_SPACE;
        end
      end
      default: begin
        scan_st = SCAN_CODE;
        if (slash_pend && b == CH_SLASH) begin
          // slash slash: both blanked, line comment from here
          slash_pend = 1'b0;
          n          = 2;
          scan_st    = SCAN_LINE;
        end else if (slash_pend && b == CH_STAR) begin
          slash_pend = 1'b0;
          n          = 2;
          scan_st    = SCAN_BLOCK;
          star_prev  = 1'b0;
        end else begin
          if (slash_pend) begin
            slash_pend = 1'b0;
            r0         = CH_SLASH;
            n          = 1;
          end
          if (b == CH_SLASH && !l) begin
            slash_pend = 1'b1;
          end else begin
            c = b;
            if (b == CH_DQUOTE) begin
              c        = CH_SPACE;
              scan_st  = SCAN_STR;
              esc_pend = 1'b0;
            end else if (b == CH_SQUOTE) begin
              c        = CH_SPACE;
              scan_st  = SCAN_CHR;
              esc_pend = 1'b0;
            end
            if (n == 0) r0 = c;
            else r1 = c;
            n++;
          end
        end
      end
    endcase
    // the final byte of a frame returns everything to the reset state
    if (l) begin
      scan_st    = SCAN_CODE;
      slash_pend = 1'b0;
      star_prev  = 1'b0;
      esc_pend   = 1'b0;
    end
    return n;
  endfunction

  // Check every transaction on both sides at the clock edge, against values
  // sampled before the edge updates anything
  always @(posedge clk) begin
    int         n;
    logic [7:0] r0;
    logic [7:0] r1;
    masked_t    e;
    row_t       t;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      // result side: compare against the oldest byte owed
      if (pop && !empty) begin
        if (masked_q.size() == 0) begin
          $display("%0t: unexpected result byte %h last %b", $time, out_byte, out_last);
          errors++;
        end else begin
          e = masked_q.pop_front();
          if (out_byte !== e.data) begin
            $display("%0t: out_byte expected %h, got %h", $time, e.data, out_byte);
            errors++;
          end
          if (out_last !== e.last) begin
            $display("%0t: out_last expected %b, got %b", $time, e.last, out_last);
            errors++;
          end
        end
      end
      // source side: predict what the accepted byte releases
      if (push && !full) begin
        n = blank_step(in_byte, in_last, r0, r1);
        if (n > 0) owe_byte(masked_t'{r0, in_last && n == 1});
        if (n > 1) owe_byte(masked_t'{r1, in_last});
        if (typed_q.size() > 0) begin
          t = typed_q.pop_front();
          if (t.chk && (n != int'(t.n) || (n > 0 && r0 != t.e0) || (n > 1 && r1 != t.e1))) begin
            $display("%0t: byte %h expected %0d out (%h %h), predicted %0d (%h %h)",
                     $time, t.b, t.n, t.e0, t.e1, n, r0, r1);
            errors++;
          end
        end
      end
      pop <= ($urandom_range(99) >= rcv_stall);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[blank_comments_and_literals] ERROR");
      $finish;
    end
  end

  // Offer one byte, idling at random first; hold it until the block takes it
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < snd_idle) begin
      push    <= 1'b0;
      in_byte <= 8'($urandom);
      in_last <= 1'($urandom);
      @(posedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    in_last <= l;
    do @(posedge clk); while (full);
    sent++;
  endtask

  // Any byte, weighted toward the ones the scanner reacts to
  function automatic logic [7:0] any_char();
    case ($urandom_range(11))
      0: return CH_SLASH;
      1: return CH_STAR;
      2: return CH_NL;
      3: return CH_BSLASH;
      4: return CH_DQUOTE;
      5: return CH_SQUOTE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Append one C-like fragment with random content to the frame: code text, comments and
  // literals (some cut short), lone slashes, or pure noise
  task automatic add_fragment();
    int         k;
    logic [7:0] c;
    k = $urandom_range(6);
    case ($urandom_range(11))
      0, 1, 2: begin
        // ordinary code text
        repeat (k + 1) frag_add(($urandom_range(7) == 0) ? CH_NL
                                : 8'($urandom_range(126, 32)));
      end
      3: begin
        frag_add(CH_SLASH);
        frag_add(CH_SLASH);
        repeat (k) begin
          c = any_char();
          frag_add((c == CH_NL) ? CH_SPACE : c);
        end
        if ($urandom_range(3) != 0) frag_add(CH_NL);
      end
      4: begin
        frag_add(CH_SLASH);
        frag_add(CH_STAR);
        repeat (k) frag_add(any_char());
        if ($urandom_range(3) != 0) begin
          frag_add(CH_STAR);
          frag_add(CH_SLASH);
        end
      end
      5: begin
        frag_add(CH_DQUOTE);
        repeat (k) begin
          if ($urandom_range(3) == 0) frag_add(CH_BSLASH);
          frag_add(any_char());
        end
        if ($urandom_range(3) != 0) frag_add(CH_DQUOTE);
      end
      6: begin
        frag_add(CH_SQUOTE);
        if ($urandom_range(1) == 0) frag_add(CH_BSLASH);
        frag_add(any_char());
        if ($urandom_range(3) != 0) frag_add(CH_SQUOTE);
      end
      7: begin
        // lone slash released by whatever follows
        frag_add(CH_SLASH);
        frag_add(any_char());
      end
      8: begin
        // run of stars before the closing slash
        frag_add(CH_SLASH);
        frag_add(CH_STAR);
        repeat (k % 3 + 1) frag_add(CH_STAR);
        frag_add(CH_SLASH);
      end
      default: begin
        repeat (k + 1) frag_add(any_char());
      end
    endcase
  endtask

  // Build one frame, mostly of medium length with a few very short ones,
  // and send it with the frame end on its final byte
  task automatic send_frame();
    int target;
    target = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(60, 8);
    frag_q.delete();
    while (frag_q.size() < target) add_fragment();
    for (int i = 0; i < frag_q.size(); i++) send_byte(frag_q[i], i == frag_q.size() - 1);
  endtask

  initial begin
    // hold reset at the start, then release it once for the whole run
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows at full rate
    for (int i = 0; i < NDIR; i++) begin
      typed_q.insert(typed_q.size(), DIR_TAB[i]);
      send_byte(DIR_TAB[i].b, DIR_TAB[i].l);
    end

    // random frames under each idling pattern in turn
    for (int p = 0; p < NPHASE; p++) begin
      snd_idle  = SND_IDLE[p];
      rcv_stall = RCV_STALL[p];
      while (sent < NDIR + PHASE_ITEMS * (p + 1)) send_frame();
    end

    // drop push and drain every byte still owed
    push <= 1'b0;
    @(posedge clk);
    while (masked_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("[blank_comments_and_literals] OK");
    end else begin
      $display("[blank_comments_and_literals] ERROR");
    end
    $finish;
  end

endmodule
